@@ src/assert_macros.svh @@
// assertion macros used by the spr_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: label");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: label");

`endif

@@ src/spr_pkg.sv @@
package spr_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned PosW     = 16;
    localparam int unsigned CountW   = 16;
    localparam int unsigned StatusW  = 2;
    localparam int unsigned OutDataW = 56;

    localparam logic [ByteW-1:0] SyncByte    = 8'hFF;
    localparam logic [ByteW-1:0] PositionCmd = 8'hA3;

    // frame status codes
    localparam logic [StatusW-1:0] StPosition  = 2'd0;
    localparam logic [StatusW-1:0] StOtherGood = 2'd1;
    localparam logic [StatusW-1:0] StBadSum    = 2'd2;
    localparam logic [StatusW-1:0] StMalformed = 2'd3;

    // result field positions inside the output tdata
    localparam int unsigned ChanLsb   = 0;
    localparam int unsigned CmdLsb    = 8;
    localparam int unsigned PosLsb    = 16;
    localparam int unsigned StatusLsb = 32;
    localparam int unsigned CountLsb  = 34;

    typedef struct packed {
        logic [CountW-1:0]  message_count;
        logic [StatusW-1:0] frame_status;
        logic [PosW-1:0]    position;
        logic [ByteW-1:0]   command;
        logic [ByteW-1:0]   channel;
    } spr_result_t;

endpackage

@@ src/spr_in_reg.sv @@
module spr_in_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [spr_pkg::ByteW-1:0]  s_axis_tdata,
    input  logic                       consume,
    output logic                       byte_valid,
    output logic [spr_pkg::ByteW-1:0]  byte_data
);
    import spr_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [ByteW-1:0] data_reg;

    assign s_axis_tready = !valid_reg || consume;
    assign valid_next    = s_axis_tready ? s_axis_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            data_reg <= s_axis_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

@@ src/spr_parser.sv @@
module spr_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    input  logic [spr_pkg::ByteW-1:0]  byte_data,
    input  logic                       out_free,
    input  logic [spr_pkg::PosW-1:0]   position_offset,
    output logic                       consume,
    output logic                       result_load,
    output spr_pkg::spr_result_t       result
);
    import spr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SYNC1   = 3'd1,
        PH_CHANNEL = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_DATA    = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [ByteW-1:0]  channel_reg, channel_next;
    logic [ByteW-1:0]  length_reg, length_next;
    logic [ByteW-1:0]  seen_reg, seen_next;
    logic [ByteW-1:0]  sum_reg, sum_next;
    logic [ByteW-1:0]  cmd_reg, cmd_next;
    logic [ByteW-1:0]  pos_hi_reg, pos_hi_next;
    logic [ByteW-1:0]  pos_lo_reg, pos_lo_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              frame_end;
    logic [StatusW-1:0] status;
    logic [PosW-1:0]   pos;

    // last byte of a frame: wrap of the 8-bit count gives 256 for length zero
    assign frame_end   = (phase_reg == PH_DATA) && (seen_next == length_reg);
    assign consume     = byte_valid && (!frame_end || out_free);
    assign result_load = consume && frame_end;

    always_comb
    begin
        phase_next   = phase_reg;
        channel_next = channel_reg;
        length_next  = length_reg;
        seen_next    = seen_reg + 8'd1;
        sum_next     = sum_reg;
        cmd_next     = cmd_reg;
        pos_hi_next  = pos_hi_reg;
        pos_lo_next  = pos_lo_reg;
        count_next   = count_reg;
        status       = StOtherGood;
        pos          = '0;
        case (phase_reg)
            PH_SYNC1:
            begin
                phase_next = (byte_data == SyncByte) ? PH_CHANNEL : PH_IDLE;
            end
            PH_CHANNEL:
            begin
                channel_next = byte_data;
                sum_next     = byte_data;
                phase_next   = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                length_next = byte_data;
                sum_next    = sum_reg + byte_data;
                seen_next   = '0;
                cmd_next    = '0;
                pos_hi_next = '0;
                pos_lo_next = '0;
                phase_next  = PH_DATA;
            end
            PH_DATA:
            begin
                if (seen_next != length_reg)
                begin
                    if (seen_next == 8'd1)
                    begin
                        cmd_next = byte_data;
                    end
                    else if (seen_next == 8'd2)
                    begin
                        pos_hi_next = byte_data;
                    end
                    else if (seen_next == 8'd3)
                    begin
                        pos_lo_next = byte_data;
                    end
                    sum_next = sum_reg + byte_data;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    if (sum_reg != byte_data)
                    begin
                        status = StBadSum;
                    end
                    else if (length_reg != 8'd1 && cmd_reg == PositionCmd)
                    begin
                        if (length_reg == 8'd2 || length_reg == 8'd3)
                        begin
                            status = StMalformed;
                        end
                        else
                        begin
                            status     = StPosition;
                            pos        = {pos_hi_reg, pos_lo_reg} + position_offset;
                            count_next = count_reg + 16'd1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = (byte_data == SyncByte) ? PH_SYNC1 : PH_IDLE;
            end
        endcase
    end

    assign result.channel       = channel_reg;
    assign result.command       = cmd_reg;
    assign result.position      = pos;
    assign result.frame_status  = status;
    assign result.message_count = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            channel_reg <= '0;
            length_reg  <= '0;
            seen_reg    <= '0;
            sum_reg     <= '0;
            cmd_reg     <= '0;
            pos_hi_reg  <= '0;
            pos_lo_reg  <= '0;
            count_reg   <= '0;
        end
        else if (consume)
        begin
            phase_reg   <= phase_next;
            channel_reg <= channel_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            cmd_reg     <= cmd_next;
            pos_hi_reg  <= pos_hi_next;
            pos_lo_reg  <= pos_lo_next;
            count_reg   <= count_next;
        end
    end

endmodule

@@ src/spr_out_reg.sv @@
module spr_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  spr_pkg::spr_result_t          result,
    output logic                          out_free,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [spr_pkg::OutDataW-1:0]  m_axis_tdata
);
    import spr_pkg::*;

    localparam int unsigned PadW = OutDataW - $bits(spr_result_t);

    logic        valid_reg;
    logic        valid_next;
    spr_result_t data_reg;

    assign out_free   = !valid_reg || m_axis_tready;
    assign valid_next = load || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{PadW{1'b0}}, data_reg};

endmodule

@@ src/servo_packet_receiver.sv @@
// Serial packet receiver for servo replies. Received bytes arrive one per transfer on
// s_axis; the block hunts for two 0xFF sync bytes, then takes a channel byte, a length
// byte L and L further bytes, the last being a checksum (sum modulo 256 of channel,
// length and payload). Length 0 means 256 bytes. Each completed frame gives one
// transfer on m_axis; every other byte gives none. A good frame whose first payload
// byte is 0xA3 and that carries at least three payload bytes reports a position
// (big-endian payload bytes two and three plus position_offset, modulo 65536) and
// bumps the message counter; status 1 marks other good frames, 2 a bad checksum and
// 3 a position frame too short to hold the position. A 0xFF inside a frame is taken
// as data. Throughput is one byte per clock: an input register feeds the parser,
// whose state is registered, and a result register holds the finished frame
// report, so a byte is taken every cycle unless a frame report is still waiting and
// the next byte would finish another frame. The last byte passes the input register
// and then the result register. position_offset is written on the cfg channel, which
// is always ready and should only be written while no frame is in flight.
module servo_packet_receiver (
    input  logic                          clk,
    input  logic                          rst_n,
    // received bytes: [7:0] rx_byte
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [spr_pkg::ByteW-1:0]     s_axis_tdata,
    // frame reports: [7:0] channel, [15:8] command, [31:16] position,
    // [33:32] frame_status, [49:34] message_count, [55:50] zero
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [spr_pkg::OutDataW-1:0]  m_axis_tdata,
    // position offset register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spr_pkg::PosW-1:0]      cfg_data
);
    import spr_pkg::*;

    logic                 offset_write;
    logic [PosW-1:0]      position_offset_reg;
    logic                 byte_valid;
    logic                 consume;
    logic [ByteW-1:0]     byte_data;
    logic                 out_free;
    logic                 result_load;
    spr_result_t          result;

    // the offset register takes any write at once
    assign cfg_ready    = 1'b1;
    assign offset_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_offset_reg <= '0;
        end
        else if (offset_write)
        begin
            position_offset_reg <= cfg_data;
        end
    end

    // input register: holds one byte until the parser consumes it
    spr_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .consume       (consume),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data)
    );

    // parser: frame state, checksum and position decode
    spr_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_data       (byte_data),
        .out_free        (out_free),
        .position_offset (position_offset_reg),
        .consume         (consume),
        .result_load     (result_load),
        .result          (result)
    );

    // result register: one frame report waits here for the consumer
    spr_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (result_load),
        .result        (result),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ src/spr_checker.sv @@
`include "assert_macros.svh"

module spr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [spr_pkg::OutDataW-1:0]  m_axis_tdata
);
    import spr_pkg::*;

    logic [ByteW-1:0]   cmd;
    logic [PosW-1:0]    pos;
    logic [StatusW-1:0] st;
    logic               stalled;

    assign cmd     = m_axis_tdata[CmdLsb +: ByteW];
    assign pos     = m_axis_tdata[PosLsb +: PosW];
    assign st      = m_axis_tdata[StatusLsb +: StatusW];
    assign stalled = m_axis_tvalid && !m_axis_tready;

    // a stalled report holds
    `ASSERT_NEXT(a_hold, clk, rst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata))
    // position is only carried by position updates
    `ASSERT_IMPLY(a_pos_zero, clk, rst_n, m_axis_tvalid && st != StPosition, pos == '0)
    // position updates and short position frames carry the position command
    `ASSERT_IMPLY(a_pos_cmd, clk, rst_n, m_axis_tvalid && st == StPosition, cmd == PositionCmd)
    `ASSERT_IMPLY(a_short_cmd, clk, rst_n, m_axis_tvalid && st == StMalformed, cmd == PositionCmd)

endmodule

bind servo_packet_receiver spr_checker u_spr_checker (.*);

@@ verif/spr_frame_checker.sv @@
`timescale 1ns / 1ps

// watches the byte, report and offset channels, predicts each frame report
// and compares it field by field with what the block sends
module spr_frame_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [spr_pkg::ByteW-1:0]    s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [spr_pkg::OutDataW-1:0] m_axis_tdata,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [spr_pkg::PosW-1:0]     cfg_data,
    output int                           mismatches,
    output int                           outstanding,
    output logic                         frame_open
);
    import spr_pkg::*;

    localparam int unsigned ResultW = $bits(spr_result_t);

    typedef enum logic [2:0] {
        HUNT,
        SYNC_SEEN,
        WANT_CHANNEL,
        WANT_LENGTH,
        IN_BODY
    } hunt_phase_t;

    hunt_phase_t      phase;
    logic [ByteW-1:0] chan_byte;
    logic [ByteW-1:0] len_byte;
    logic [ByteW-1:0] body_count;
    logic [ByteW-1:0] sum_acc;
    logic [ByteW-1:0] cmd_byte;
    logic [ByteW-1:0] pos_hi;
    logic [ByteW-1:0] pos_lo;
    logic [CountW-1:0] update_count;
    logic [PosW-1:0]   pos_offset;

    spr_result_t expected_reports[$];

    initial mismatches = 0;
    initial outstanding = 0;
    initial frame_open = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // one received byte through the frame hunter
    task automatic take_byte(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] n;
        spr_result_t      r;
        case (phase)
            SYNC_SEEN:
                phase = (b == SyncByte) ? WANT_CHANNEL : HUNT;
            WANT_CHANNEL:
            begin
                chan_byte = b;
                sum_acc   = b;
                phase     = WANT_LENGTH;
            end
            WANT_LENGTH:
            begin
                len_byte   = b;
                sum_acc    = sum_acc + b;
                body_count = '0;
                cmd_byte   = '0;
                pos_hi     = '0;
                pos_lo     = '0;
                phase      = IN_BODY;
            end
            IN_BODY:
            begin
                n = body_count + 8'd1;
                body_count = n;
                if (n != len_byte)
                begin
                    if (n == 8'd1)
                        cmd_byte = b;
                    else if (n == 8'd2)
                        pos_hi = b;
                    else if (n == 8'd3)
                        pos_lo = b;
                    sum_acc = sum_acc + b;
                end
                else
                begin
                    // checksum byte closes the frame
                    phase = HUNT;
                    r = '0;
                    r.channel = chan_byte;
                    r.command = cmd_byte;
                    if (sum_acc != b)
                        r.frame_status = StBadSum;
                    else if (len_byte != 8'd1 && cmd_byte == PositionCmd)
                    begin
                        if (len_byte == 8'd2 || len_byte == 8'd3)
                            r.frame_status = StMalformed;
                        else
                        begin
                            r.frame_status = StPosition;
                            r.position     = {pos_hi, pos_lo} + pos_offset;
                            update_count   = update_count + 16'd1;
                        end
                    end
                    else
                        r.frame_status = StOtherGood;
                    r.message_count = update_count;
                    expected_reports.insert(expected_reports.size(), r);
                end
            end
            default:
                phase = (b == SyncByte) ? SYNC_SEEN : HUNT;
        endcase
    endtask

    task automatic check_report(input logic [OutDataW-1:0] data);
        spr_result_t got;
        spr_result_t want;
        got = data[ResultW-1:0];
        if (expected_reports.size() == 0)
        begin
            report("unexpected frame report", data[31:0], '0);
            return;
        end
        want = expected_reports.pop_front();
        if (got.channel != want.channel)
            report("channel", 32'(got.channel), 32'(want.channel));
        if (got.command != want.command)
            report("command", 32'(got.command), 32'(want.command));
        if (got.position != want.position)
            report("position", 32'(got.position), 32'(want.position));
        if (got.frame_status != want.frame_status)
            report("frame_status", 32'(got.frame_status), 32'(want.frame_status));
        if (got.message_count != want.message_count)
            report("message_count", 32'(got.message_count), 32'(want.message_count));
        if (data[OutDataW-1:ResultW] != '0)
            report("padding", 32'(data[OutDataW-1:ResultW]), '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase        = HUNT;
            chan_byte    = '0;
            len_byte     = '0;
            body_count   = '0;
            sum_acc      = '0;
            cmd_byte     = '0;
            pos_hi       = '0;
            pos_lo       = '0;
            update_count = '0;
            pos_offset   = '0;
            expected_reports.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                pos_offset = cfg_data;
            // a report never belongs to a byte taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
                check_report(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata);
        end
        outstanding = expected_reports.size();
        frame_open  = (phase != HUNT);
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import spr_pkg::*;

    // worst case is far below this, even with both sides stalling hard
    localparam int CycleLimit = 300000;

    logic clk;
    logic rst_n = 1'b0;

    // byte side
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [ByteW-1:0] s_axis_tdata  = '0;    // [7:0] rx_byte

    // report side
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;      // [7:0] channel, [15:8] command, [31:16] position,
                                            // [33:32] frame_status, [49:34] message_count

    // offset register write
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [PosW-1:0] cfg_data  = '0;

    int   mismatches;
    int   outstanding;
    logic frame_open;

    // idle chances in percent for each side
    int tx_idle_pct = 28;
    int rx_idle_pct = 48;

    int bytes_sent  = 0;
    int cycle_count = 0;

    servo_packet_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    spr_frame_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .frame_open    (frame_open)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // report side back-pressure, redrawn every cycle
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // mostly random payload, with a fair share of sync-looking bytes
    function automatic logic [ByteW-1:0] payload_byte();
        if ($urandom_range(7) == 0)
            return SyncByte;
        return ByteW'($urandom_range(255));
    endfunction

    // one byte transfer; called at a rising edge, returns at the accepting edge
    // with tvalid still high so back-to-back bytes need no extra assignment
    task automatic send_byte(input logic [ByteW-1:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        bytes_sent++;
    endtask

    // whole frame: sync pair, channel, length, body; length 0 means 256 body bytes
    task automatic send_frame(input logic [ByteW-1:0] chan, input logic [ByteW-1:0] len,
                              input logic [ByteW-1:0] cmd, input logic [ByteW-1:0] hi,
                              input logic [ByteW-1:0] lo, input bit bad_sum);
        int               body_bytes;
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] b;
        body_bytes = (len == 0) ? 256 : int'(len);
        send_byte(SyncByte);
        send_byte(SyncByte);
        send_byte(chan);
        send_byte(len);
        sum = chan + len;
        for (int i = 1; i < body_bytes; i++)
        begin
            case (i)
                1:       b = cmd;
                2:       b = hi;
                3:       b = lo;
                default: b = payload_byte();
            endcase
            sum = sum + b;
            send_byte(b);
        end
        // corrupt the checksum by a nonzero amount
        if (bad_sum)
            sum = sum ^ ByteW'($urandom_range(255, 1));
        send_byte(sum);
    endtask

    // stop sending and wait, sampling on the falling edge, until no report is owed
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // push filler until the parser is back to hunting for sync; a filler of 1
    // gives a one-byte frame if it lands on the length byte
    task automatic close_frame();
        s_axis_tvalid <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!frame_open)
                break;
            @(posedge clk);
            send_byte(8'h01);
            s_axis_tvalid <= 1'b0;
        end
        @(posedge clk);
    endtask

    // parser idle, every report in, then a wait for the pipeline to empty
    task automatic settle();
        close_frame();
        wait_drained();
        repeat (8) @(posedge clk);
    endtask

    task automatic write_offset(input logic [PosW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // noise, then a lone sync byte followed by a non-sync byte
        send_byte(8'h00);
        send_byte(SyncByte);
        send_byte(8'h12);
        // position frame with sync values as channel and position bytes, largest position
        send_frame(8'hFF, 8'd4, PositionCmd, 8'hFF, 8'hFF, 1'b0);
        // checksum-only frame: no payload, command reads as zero
        send_frame(8'h00, 8'd1, 8'h00, 8'h00, 8'h00, 1'b0);
        // position command with no room for the position bytes
        send_frame(8'h5A, 8'd2, PositionCmd, 8'h00, 8'h00, 1'b0);
        // position command but the checksum is wrong
        send_frame(8'h81, 8'd3, PositionCmd, 8'h12, 8'h34, 1'b1);
    endtask

    // random traffic: mostly well-formed frames, some noise and cut-off frames
    task automatic run_random(input int target, input bit hold_midway);
        int               start_count;
        int               pick;
        int               lsel;
        logic [ByteW-1:0] len;
        logic [ByteW-1:0] cmd;
        bit               paused;
        start_count = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start_count < target)
        begin
            // hold off once until every owed report has come back
            if (hold_midway && !paused && bytes_sent - start_count > target / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                lsel = $urandom_range(99);
                if (lsel == 0)
                    len = 8'd0;
                else if (lsel == 1)
                    len = 8'd255;
                else if (lsel < 25)
                    len = ByteW'($urandom_range(3, 2));
                else
                    len = ByteW'($urandom_range(10, 1));
                cmd = $urandom_range(1) ? PositionCmd : payload_byte();
                send_frame(ByteW'($urandom_range(255)), len, cmd,
                           payload_byte(), payload_byte(), $urandom_range(99) < 15);
            end
            else if (pick < 86)
            begin
                repeat ($urandom_range(4, 1))
                    send_byte(($urandom_range(3) == 0) ? SyncByte : ByteW'($urandom_range(255)));
            end
            else
            begin
                // header with a body cut short; whatever follows is taken as body
                len = ByteW'($urandom_range(8, 2));
                send_byte(SyncByte);
                send_byte(SyncByte);
                send_byte(ByteW'($urandom_range(255)));
                send_byte(len);
                repeat ($urandom_range(int'(len) - 1))
                    send_byte(payload_byte());
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value first, then the directed frames
        write_offset(16'h0000);
        run_directed();

        // sender idles less than the receiver, offset at its top end
        settle();
        write_offset(16'hFFFF);
        run_random(360, 1'b1);

        // the other way round, random offset
        settle();
        tx_idle_pct = 48;
        rx_idle_pct = 28;
        write_offset(PosW'($urandom));
        run_random(360, 1'b0);

        // full rate on both sides
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_offset(PosW'($urandom));
        run_random(360, 1'b0);

        // drain whatever is still owed, then a margin for stray reports
        close_frame();
        wait_drained();
        repeat (12) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
